// File: rtl/led_pkg.sv
// Shared types and constants of the line editor with history.
package led_pkg;

  localparam int unsigned TypeLimit = 79;
  localparam int unsigned KeepLen = 78;
  localparam int unsigned HistSlots = 9;
  localparam int unsigned LineBytes = 80;

  typedef enum logic [3:0] {
    KEY_OTHER = 4'd0,
    KEY_BACK = 4'd1,
    KEY_ENTER = 4'd2,
    KEY_HOME = 4'd3,
    KEY_END = 4'd4,
    KEY_LEFT = 4'd5,
    KEY_RIGHT = 4'd6,
    KEY_PGUP = 4'd7,
    KEY_PGDN = 4'd8,
    KEY_INS = 4'd9,
    KEY_DEL = 4'd10,
    KEY_CONSOLE = 4'd11,
    KEY_OPEN = 4'd12,
    KEY_R13 = 4'd13,
    KEY_R14 = 4'd14,
    KEY_R15 = 4'd15
  } key_e;

  // Classified command handed from the front end to the back end.
  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CHAR,
    CMD_BACK,
    CMD_ENTER,
    CMD_HOME,
    CMD_END,
    CMD_LEFT,
    CMD_RIGHT,
    CMD_PGUP,
    CMD_PGDN,
    CMD_INS,
    CMD_DEL,
    CMD_OPEN
  } cmd_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] ch;
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD,
    ST_INS_WR,
    ST_DEL_RD,
    ST_DEL_WR,
    ST_SUB_RD,
    ST_SUB_WR,
    ST_SUB_EMIT,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_CLR,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_STATUS
  } state_e;

endpackage

// File: rtl/led_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module led_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 80
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/led_front.sv
// Front end: accepts key events, classifies them and holds them in a small queue.
module led_front #(
  parameter int unsigned TypeLimit = led_pkg::TypeLimit,
  parameter int unsigned LineBytes = led_pkg::LineBytes
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [3:0]             key_class_i,
  input  logic [7:0]             char_code_i,
  input  logic [$clog2(LineBytes+1)-1:0] len_i,
  input  logic                   busy_i,
  output logic                   cmd_valid_o,
  input  logic                   cmd_ready_i,
  output led_pkg::cmd_t          cmd_o
);

  localparam int unsigned LW = $clog2(LineBytes + 1);
  localparam int unsigned Cap = (TypeLimit < LineBytes) ? TypeLimit : LineBytes;

  // The line length that classification needs is only settled once the back
  // end is idle and the queue is empty, so one entry is enough.
  logic          full_q;
  led_pkg::cmd_t ent_q;
  led_pkg::cmd_t cls;
  logic          printable;

  assign in_ready_o = !full_q && !busy_i;
  assign printable = (char_code_i >= 8'h20) && (char_code_i < 8'h7f) &&
                     (key_class_i != led_pkg::KEY_CONSOLE) &&
                     (len_i < LW'(Cap));

  always_comb begin
    cls.ch = char_code_i;
    if (key_class_i == led_pkg::KEY_OPEN) begin
      cls.cmd = led_pkg::CMD_OPEN;
    end else if (printable) begin
      cls.cmd = led_pkg::CMD_CHAR;
    end else begin
      unique case (led_pkg::key_e'(key_class_i))
        led_pkg::KEY_BACK:  cls.cmd = led_pkg::CMD_BACK;
        led_pkg::KEY_ENTER: cls.cmd = led_pkg::CMD_ENTER;
        led_pkg::KEY_HOME:  cls.cmd = led_pkg::CMD_HOME;
        led_pkg::KEY_END:   cls.cmd = led_pkg::CMD_END;
        led_pkg::KEY_LEFT:  cls.cmd = led_pkg::CMD_LEFT;
        led_pkg::KEY_RIGHT: cls.cmd = led_pkg::CMD_RIGHT;
        led_pkg::KEY_PGUP:  cls.cmd = led_pkg::CMD_PGUP;
        led_pkg::KEY_PGDN:  cls.cmd = led_pkg::CMD_PGDN;
        led_pkg::KEY_INS:   cls.cmd = led_pkg::CMD_INS;
        led_pkg::KEY_DEL:   cls.cmd = led_pkg::CMD_DEL;
        default:            cls.cmd = led_pkg::CMD_NONE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      full_q <= 1'b0;
    end else if (in_valid_i && in_ready_o) begin
      full_q <= 1'b1;
    end else if (cmd_ready_i) begin
      full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ent_q <= cls;
    end
  end

  assign cmd_valid_o = full_q;
  assign cmd_o = ent_q;

endmodule

// File: rtl/led_back.sv
// Back end: carries out classified commands on the line and history memories.
module led_back #(
  parameter int unsigned TypeLimit = led_pkg::TypeLimit,
  parameter int unsigned KeepLen = led_pkg::KeepLen,
  parameter int unsigned HistSlots = led_pkg::HistSlots,
  parameter int unsigned LineBytes = led_pkg::LineBytes
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cmd_valid_i,
  output logic                           cmd_ready_o,
  input  led_pkg::cmd_t                  cmd_i,
  output logic [$clog2(LineBytes+1)-1:0] len_o,
  output logic                           busy_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           result_kind_o,
  output logic [7:0]                     text0_o,
  output logic [7:0]                     text1_o,
  output logic [7:0]                     text2_o,
  output logic [7:0]                     text3_o,
  output logic [2:0]                     text_count_o,
  output logic                           last_o,
  output logic [6:0]                     cursor_pos_o,
  output logic [6:0]                     line_length_o,
  output logic                           insert_mode_o,
  output logic signed [4:0]              history_pos_o
);

  localparam int unsigned LW = $clog2(LineBytes + 1);
  localparam int unsigned AW = $clog2(LineBytes);
  localparam int unsigned HD = HistSlots * LineBytes;
  localparam int unsigned HW = $clog2(HD);
  localparam int unsigned SW = $clog2(HistSlots + 1);
  localparam int unsigned KeepEff = (KeepLen < LineBytes) ? KeepLen : LineBytes;
  localparam int unsigned HistCap = HistSlots - 1;
  localparam int unsigned CW = LW + 1;

  led_pkg::state_e state_q, state_d;

  // The line length is tracked as a register; the line memory keeps zeros
  // past it, and a recall reads the history memory only below the kept length.
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] cur_q, cur_d;
  logic          ins_q, ins_d;
  logic [SW-1:0] hcnt_q, hcnt_d;
  logic signed [SW:0] hidx_q, hidx_d;
  // Kept length of each history slot; an entry past the count reads empty.
  logic [LW-1:0] hlen_q [HistSlots];
  logic [LW-1:0] hlen_d [HistSlots];

  logic [CW-1:0] i_q, i_d;   // walking index
  logic [CW-1:0] j_q, j_d;   // secondary index / bound
  logic [SW-1:0] s_q, s_d;   // history slot being walked
  logic [7:0] ch_q, ch_d;
  logic [7:0] buf_q [4];
  logic [7:0] buf_d [4];
  logic [2:0] bcnt_q, bcnt_d;
  logic [LW-1:0] sub_q, sub_d;

  // Line memory ports.
  logic          l_we;
  logic [AW-1:0] l_wa, l_ra;
  logic [7:0]    l_wd, l_rd;
  // History memory ports.
  logic          h_we;
  logic [HW-1:0] h_wa, h_ra;
  logic [7:0]    h_wd, h_rd;

  // Clearing pass of the line memory after reset.
  logic          init_q;
  logic [AW-1:0] init_a_q;

  // Output register.
  logic       ov_q, ov_d;
  logic       okind_q, okind_d;
  logic [7:0] ot_q [4];
  logic [7:0] ot_d [4];
  logic [2:0] ocnt_q, ocnt_d;
  logic       olast_q, olast_d;

  logic [AW-1:0] lwa_c, lra_c;
  logic [HW-1:0] hwa_c, hra_c;
  logic          lwe_c, hwe_c;
  logic [7:0]    lwd_c, hwd_c;

  led_ram #(.Width(8), .Depth(LineBytes)) u_line (
    .clk_i  (clk_i),
    .we_i   (l_we),
    .waddr_i(l_wa),
    .wdata_i(l_wd),
    .raddr_i(l_ra),
    .rdata_o(l_rd)
  );

  led_ram #(.Width(8), .Depth(HD)) u_hist (
    .clk_i  (clk_i),
    .we_i   (h_we),
    .waddr_i(h_wa),
    .wdata_i(h_wd),
    .raddr_i(h_ra),
    .rdata_o(h_rd)
  );

  assign l_we = init_q ? 1'b1 : lwe_c;
  assign l_wa = init_q ? init_a_q : lwa_c;
  assign l_wd = init_q ? 8'h00 : lwd_c;
  assign l_ra = lra_c;
  assign h_we = hwe_c;
  assign h_wa = hwa_c;
  assign h_wd = hwd_c;
  assign h_ra = hra_c;

  function automatic logic [HW-1:0] haddr(logic [SW-1:0] slot, logic [CW-1:0] pos);
    logic [HW+CW-1:0] a;
    a = (HW + CW)'(slot) * (HW + CW)'(LineBytes) + (HW + CW)'(pos);
    return a[HW-1:0];
  endfunction

  always_comb begin
    state_d = state_q;
    len_d = len_q;
    cur_d = cur_q;
    ins_d = ins_q;
    hcnt_d = hcnt_q;
    hidx_d = hidx_q;
    hlen_d = hlen_q;
    i_d = i_q;
    j_d = j_q;
    s_d = s_q;
    ch_d = ch_q;
    buf_d = buf_q;
    bcnt_d = bcnt_q;
    sub_d = sub_q;
    ov_d = ov_q;
    okind_d = okind_q;
    ot_d = ot_q;
    ocnt_d = ocnt_q;
    olast_d = olast_q;
    lwe_c = 1'b0;
    lwa_c = '0;
    lwd_c = '0;
    lra_c = '0;
    hwe_c = 1'b0;
    hwa_c = '0;
    hwd_c = '0;
    hra_c = '0;
    cmd_ready_o = 1'b0;

    if (ov_q && out_ready_i) begin
      ov_d = 1'b0;
    end

    unique case (state_q)
      led_pkg::ST_IDLE: begin
        if (cmd_valid_i && !init_q) begin
          cmd_ready_o = 1'b1;
          ch_d = cmd_i.ch;
          state_d = led_pkg::ST_STATUS;
          unique case (cmd_i.cmd)
            led_pkg::CMD_OPEN: begin
              cur_d = '0;
              hidx_d = '1;
              i_d = '0;
              state_d = led_pkg::ST_CLR;
            end
            led_pkg::CMD_CHAR: begin
              if (cur_q > len_q) begin
                cur_d = len_q;
              end
              if (ins_q) begin
                i_d = CW'(len_q);
                state_d = led_pkg::ST_INS_RD;
              end else begin
                i_d = CW'((cur_q > len_q) ? len_q : cur_q);
                state_d = led_pkg::ST_INS_WR;
              end
            end
            led_pkg::CMD_BACK: begin
              if (cur_q > 0 && cur_q <= len_q) begin
                cur_d = cur_q - 1'b1;
                i_d = CW'(cur_q - 1'b1);
                state_d = led_pkg::ST_DEL_RD;
              end
            end
            led_pkg::CMD_DEL: begin
              if (cur_q < len_q) begin
                i_d = CW'(cur_q);
                state_d = led_pkg::ST_DEL_RD;
              end
            end
            led_pkg::CMD_ENTER: begin
              if (len_q != 0) begin
                sub_d = (len_q < LW'(KeepEff)) ? len_q : LW'(KeepEff);
                // The state after the submit is set here, so every chunk
                // already shows it; j keeps the old length for clearing.
                hcnt_d = (hcnt_q + 1'b1 > SW'(HistCap)) ? SW'(HistCap) : hcnt_q + 1'b1;
                hidx_d = '1;
                cur_d = '0;
                j_d = CW'(len_q);
                len_d = '0;
                // Age the history first: slots walk from oldest-but-one down to slot 0.
                s_d = SW'(HistSlots - 2);
                i_d = '0;
                state_d = (HistSlots > 2) ? led_pkg::ST_SHIFT_RD : led_pkg::ST_SUB_RD;
                for (int k = HistSlots - 1; k > 0; k--) begin
                  hlen_d[k] = hlen_q[k-1];
                end
                hlen_d[0] = sub_d;
              end
            end
            led_pkg::CMD_HOME: cur_d = '0;
            led_pkg::CMD_END: cur_d = len_q;
            led_pkg::CMD_LEFT: if (cur_q > 0) cur_d = cur_q - 1'b1;
            led_pkg::CMD_RIGHT: begin
              if (cur_q < len_q && cur_q < LW'(TypeLimit)) cur_d = cur_q + 1'b1;
            end
            led_pkg::CMD_INS: ins_d = !ins_q;
            led_pkg::CMD_PGUP: begin
              cur_d = '0;
              if (hidx_q + 1 > $signed({1'b0, hcnt_q}) ||
                  hidx_q + 1 > $signed((SW+1)'(HistCap))) begin
                hidx_d = '0;
              end else begin
                hidx_d = hidx_q + 1'b1;
              end
              i_d = '0;
              state_d = led_pkg::ST_CLR;
            end
            led_pkg::CMD_PGDN: begin
              cur_d = '0;
              if (hidx_q - 1 < -1) begin
                hidx_d = (hcnt_q < SW'(HistCap)) ? (SW+1)'($signed({1'b0, hcnt_q}) - 1)
                                                 : (SW+1)'(HistCap - 1);
              end else begin
                hidx_d = hidx_q - 1'b1;
              end
              i_d = '0;
              state_d = led_pkg::ST_CLR;
            end
            default: ;
          endcase
        end
      end

      // Insert: walk from len down to cursor moving each byte right; overwrite writes only the cursor byte.
      led_pkg::ST_INS_RD: begin
        if (i_q > CW'(cur_q)) begin
          lra_c = AW'(i_q - 1'b1);
          state_d = led_pkg::ST_INS_WR;
        end else begin
          state_d = led_pkg::ST_INS_WR;
        end
      end
      led_pkg::ST_INS_WR: begin
        if (ins_q && i_q > CW'(cur_q)) begin
          lwe_c = 1'b1;
          lwa_c = AW'(i_q);
          lwd_c = l_rd;
          i_d = i_q - 1'b1;
          state_d = led_pkg::ST_INS_RD;
        end else begin
          lwe_c = 1'b1;
          lwa_c = AW'(cur_q);
          lwd_c = ch_q;
          cur_d = cur_q + 1'b1;
          if (ins_q || cur_q >= len_q) begin
            len_d = len_q + 1'b1;
          end
          state_d = led_pkg::ST_STATUS;
        end
      end

      // Remove: shift the tail left from i, then zero the old last byte.
      led_pkg::ST_DEL_RD: begin
        if (i_q + 1 < CW'(len_q)) begin
          lra_c = AW'(i_q + 1'b1);
        end
        state_d = led_pkg::ST_DEL_WR;
      end
      led_pkg::ST_DEL_WR: begin
        lwe_c = 1'b1;
        lwa_c = AW'(i_q);
        if (i_q + 1 < CW'(len_q)) begin
          lwd_c = l_rd;
          i_d = i_q + 1'b1;
          state_d = led_pkg::ST_DEL_RD;
        end else begin
          lwd_c = 8'h00;
          len_d = len_q - 1'b1;
          state_d = led_pkg::ST_STATUS;
        end
      end

      // History aging: copy slot s into slot s+1, up to KeepLen bytes (at most LineBytes).
      led_pkg::ST_SHIFT_RD: begin
        hra_c = haddr(s_q, i_q);
        state_d = led_pkg::ST_SHIFT_WR;
      end
      led_pkg::ST_SHIFT_WR: begin
        hwe_c = 1'b1;
        hwa_c = haddr(s_q + 1'b1, i_q);
        hwd_c = h_rd;
        if (i_q + 1 < CW'(KeepEff)) begin
          i_d = i_q + 1'b1;
          state_d = led_pkg::ST_SHIFT_RD;
        end else if (s_q != 0) begin
          i_d = '0;
          s_d = s_q - 1'b1;
          state_d = led_pkg::ST_SHIFT_RD;
        end else begin
          i_d = '0;
          state_d = led_pkg::ST_SUB_RD;
        end
      end

      // Submit: read the line, write slot 0, clear the line, emit chunks.
      led_pkg::ST_SUB_RD: begin
        lra_c = AW'(i_q);
        state_d = led_pkg::ST_SUB_WR;
      end
      led_pkg::ST_SUB_WR: begin
        // Keep reading the same byte so the data survives an output stall.
        lra_c = AW'(i_q);
        if (!ov_d) begin
          lwe_c = 1'b1;
          lwa_c = AW'(i_q);
          lwd_c = 8'h00;
          hwe_c = 1'b1;
          hwa_c = haddr('0, i_q);
          hwd_c = l_rd;
          buf_d[bcnt_q[1:0]] = l_rd;
          bcnt_d = bcnt_q + 1'b1;
          i_d = i_q + 1'b1;
          if (bcnt_q == 3'd3 || i_q + 1 == CW'(sub_q)) begin
            state_d = led_pkg::ST_SUB_EMIT;
          end else begin
            state_d = led_pkg::ST_SUB_RD;
          end
        end
      end
      led_pkg::ST_SUB_EMIT: begin
        if (!ov_d) begin
          ov_d = 1'b1;
          okind_d = 1'b1;
          for (int k = 0; k < 4; k++) begin
            ot_d[k] = (3'(k) < bcnt_q) ? buf_q[k] : 8'h00;
          end
          ocnt_d = bcnt_q;
          olast_d = 1'b0;
          bcnt_d = '0;
          if (i_q == CW'(sub_q)) begin
            // Clear the rest of the line beyond the kept part.
            state_d = led_pkg::ST_CLR;
          end else begin
            state_d = led_pkg::ST_SUB_RD;
          end
        end
      end

      // Zero the line from i up to its old length (or j for a submit).
      led_pkg::ST_CLR: begin
        if (i_q < CW'(len_q) || i_q < j_q) begin
          lwe_c = 1'b1;
          lwa_c = AW'(i_q);
          lwd_c = 8'h00;
          i_d = i_q + 1'b1;
        end else begin
          len_d = '0;
          j_d = '0;
          i_d = '0;
          if (hidx_q >= 0 && !(hidx_q > $signed({1'b0, hcnt_q}))) begin
            s_d = SW'(hidx_q);
            state_d = led_pkg::ST_LOAD_RD;
          end else begin
            state_d = led_pkg::ST_STATUS;
          end
        end
      end

      // Recall: copy the slot's kept prefix into the line.
      led_pkg::ST_LOAD_RD: begin
        if ({1'b0, s_q} >= {1'b0, hcnt_q} || i_q >= CW'(hlen_q[s_q])) begin
          len_d = (s_q < hcnt_q) ? hlen_q[s_q] : '0;
          state_d = led_pkg::ST_STATUS;
        end else begin
          hra_c = haddr(s_q, i_q);
          state_d = led_pkg::ST_LOAD_WR;
        end
      end
      led_pkg::ST_LOAD_WR: begin
        lwe_c = 1'b1;
        lwa_c = AW'(i_q);
        lwd_c = h_rd;
        i_d = i_q + 1'b1;
        state_d = led_pkg::ST_LOAD_RD;
      end

      led_pkg::ST_STATUS: begin
        if (!ov_d) begin
          ov_d = 1'b1;
          okind_d = 1'b0;
          for (int k = 0; k < 4; k++) ot_d[k] = 8'h00;
          ocnt_d = '0;
          olast_d = 1'b1;
          state_d = led_pkg::ST_IDLE;
        end
      end

      default: state_d = led_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= led_pkg::ST_IDLE;
      len_q <= '0;
      cur_q <= '0;
      ins_q <= 1'b1;
      hcnt_q <= '0;
      hidx_q <= '1;
      for (int k = 0; k < HistSlots; k++) hlen_q[k] <= '0;
      i_q <= '0;
      j_q <= '0;
      s_q <= '0;
      bcnt_q <= '0;
      sub_q <= '0;
      ov_q <= 1'b0;
      init_q <= 1'b1;
      init_a_q <= '0;
    end else begin
      state_q <= state_d;
      len_q <= len_d;
      cur_q <= cur_d;
      ins_q <= ins_d;
      hcnt_q <= hcnt_d;
      hidx_q <= hidx_d;
      hlen_q <= hlen_d;
      i_q <= i_d;
      j_q <= j_d;
      s_q <= s_d;
      bcnt_q <= bcnt_d;
      sub_q <= sub_d;
      ov_q <= ov_d;
      if (init_q) begin
        if (init_a_q == AW'(LineBytes - 1)) begin
          init_q <= 1'b0;
        end
        init_a_q <= init_a_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q <= ch_d;
    buf_q <= buf_d;
    okind_q <= okind_d;
    ot_q <= ot_d;
    ocnt_q <= ocnt_d;
    olast_q <= olast_d;
  end

  // Status fields are sampled live: the state of an event is settled before
  // its first result is offered and holds until its last result has left.
  assign len_o = len_q;
  assign busy_o = (state_q != led_pkg::ST_IDLE) || ov_q || init_q;
  assign out_valid_o = ov_q;
  assign result_kind_o = okind_q;
  assign text0_o = ot_q[0];
  assign text1_o = ot_q[1];
  assign text2_o = ot_q[2];
  assign text3_o = ot_q[3];
  assign text_count_o = ocnt_q;
  assign last_o = olast_q;
  assign cursor_pos_o = 7'(cur_q);
  assign line_length_o = 7'(len_q);
  assign insert_mode_o = ins_q;
  assign history_pos_o = 5'(hidx_q);

endmodule

// File: rtl/line_editor_with_history_unit.sv
// Top level of the line editor with recall history.
//
//  Channel  Direction  Handshake             Payload
//  in       input      in_valid_i/in_ready_o   key_class_i, char_code_i
//  out      output     out_valid_o/out_ready_i result_kind_o .. history_pos_o
//
// Edits that shift the line walk it byte by byte; a submit copies each aged
// history slot, up to KeepLen bytes, into the next one, which sets the worst
// case. After reset the line memory is cleared, and during that pass no
// transaction is accepted. The next event is accepted once every result of
// the previous one has been taken; a stalled output simply holds the back end.
module line_editor_with_history_unit #(
  parameter int unsigned TypeLimit = led_pkg::TypeLimit,
  parameter int unsigned KeepLen = led_pkg::KeepLen,
  parameter int unsigned HistSlots = led_pkg::HistSlots,
  parameter int unsigned LineBytes = led_pkg::LineBytes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [3:0]        key_class_i,
  input  logic [7:0]        char_code_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              result_kind_o,
  output logic [7:0]        text0_o,
  output logic [7:0]        text1_o,
  output logic [7:0]        text2_o,
  output logic [7:0]        text3_o,
  output logic [2:0]        text_count_o,
  output logic              last_o,
  output logic [6:0]        cursor_pos_o,
  output logic [6:0]        line_length_o,
  output logic              insert_mode_o,
  output logic signed [4:0] history_pos_o
);

  logic                           cmd_valid, cmd_ready, busy;
  led_pkg::cmd_t                  cmd;
  logic [$clog2(LineBytes+1)-1:0] len;

  // The front end classifies a key event against the current line length.
  led_front #(.TypeLimit(TypeLimit), .LineBytes(LineBytes)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .key_class_i(key_class_i),
    .char_code_i(char_code_i),
    .len_i      (len),
    .busy_i     (busy),
    .cmd_valid_o(cmd_valid),
    .cmd_ready_i(cmd_ready),
    .cmd_o      (cmd)
  );

  // The back end owns the line and history memories and produces results.
  led_back #(
    .TypeLimit(TypeLimit), .KeepLen(KeepLen),
    .HistSlots(HistSlots), .LineBytes(LineBytes)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_valid_i  (cmd_valid),
    .cmd_ready_o  (cmd_ready),
    .cmd_i        (cmd),
    .len_o        (len),
    .busy_o       (busy),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_kind_o(result_kind_o),
    .text0_o      (text0_o),
    .text1_o      (text1_o),
    .text2_o      (text2_o),
    .text3_o      (text3_o),
    .text_count_o (text_count_o),
    .last_o       (last_o),
    .cursor_pos_o (cursor_pos_o),
    .line_length_o(line_length_o),
    .insert_mode_o(insert_mode_o),
    .history_pos_o(history_pos_o)
  );

endmodule
